/* design/fas_pkg.sv */
// Shared types, codes and constants for the fiducial alignment sequencer.
// No dependencies; fas_csr, fas_step and the top level import this package.
package fas_pkg;

   // Phase codes, carried on the result word as well
   typedef enum logic [2:0] {
      PH_WAIT   = 3'd0,
      PH_STRAFE = 3'd1,
      PH_ROTATE = 3'd2,
      PH_DIST   = 3'd3,
      PH_FINAL  = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   // Drive command codes
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_STOP  = 3'd1,
      CMD_LEFT  = 3'd2,
      CMD_RIGHT = 3'd3,
      CMD_CCW   = 3'd4,
      CMD_CW    = 3'd5,
      CMD_FWD   = 3'd6,
      CMD_BACK  = 3'd7
   } cmd_type;

   // Configuration port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILT_THRESHOLD   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_WINDOW    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_AREA_TOLERANCE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_AREA_TARGET      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRAFE_GAIN      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_GAIN       = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROTATE_SPEED     = 3'd7;

   // Register reset values
   localparam logic [14:0]        RST_OFFSET_THRESHOLD = 15'd768;
   localparam logic [15:0]        RST_TILT_THRESHOLD   = 16'd48;
   localparam logic [14:0]        RST_OFFSET_WINDOW    = 15'd2560;
   localparam logic [15:0]        RST_AREA_TOLERANCE   = 16'd655;
   localparam logic signed [16:0] RST_AREA_TARGET      = -17'sd1;
   localparam logic [6:0]         RST_STRAFE_GAIN      = 7'd23;
   localparam logic [6:0]         RST_DRIVE_GAIN       = 7'd18;
   localparam logic [6:0]         RST_ROTATE_SPEED     = 7'd18;

   // Speed ceiling: 100 percent in Q7.8
   localparam logic [14:0] SPEED_MAX = 15'd25600;
   // Full scale of the Q0.16 area
   localparam logic [16:0] AREA_FULL = 17'h10000;

   // Configuration register set
   typedef struct packed {
      logic [14:0]        offset_threshold;
      logic [15:0]        tilt_threshold;
      logic [14:0]        offset_window;
      logic [15:0]        area_tolerance;
      logic signed [16:0] area_target;
      logic [6:0]         strafe_gain;
      logic [6:0]         drive_gain;
      logic [6:0]         rotate_speed;
   } cfg_type;

   // One camera sample
   typedef struct packed {
      logic               restart;
      logic               target_seen;
      logic signed [15:0] offset_sample;
      logic [15:0]        area_sample;
      logic [15:0]        left_corner_y;
      logic [15:0]        right_corner_y;
   } req_word_type;

   // One drive command
   typedef struct packed {
      cmd_type     drive_command;
      logic [14:0] drive_speed;
      phase_type   phase;
      logic        done_res;
   } rsp_word_type;

endpackage

/* design/fas_req_if.sv */
// Sample channel: valid/ready handshake carrying one camera sample word.
// Standalone; no package dependency.
interface fas_req_if;
   logic               valid;
   logic               ready;
   logic               restart;
   logic               target_seen;
   logic signed [15:0] offset_sample;
   logic [15:0]        area_sample;
   logic [15:0]        left_corner_y;
   logic [15:0]        right_corner_y;

   modport source (output valid, restart, target_seen, offset_sample, area_sample,
                   left_corner_y, right_corner_y, input ready);
   modport sink   (input valid, restart, target_seen, offset_sample, area_sample,
                   left_corner_y, right_corner_y, output ready);
endinterface

/* design/fas_rsp_if.sv */
// Command channel: valid/ready handshake carrying one drive command word.
// Standalone; no package dependency.
interface fas_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  drive_command;
   logic [14:0] drive_speed;
   logic [2:0]  phase;
   logic        done_res;

   modport source (output valid, drive_command, drive_speed, phase, done_res,
                   input ready);
   modport sink   (input valid, drive_command, drive_speed, phase, done_res,
                   output ready);
endinterface

/* design/fas_csr.sv */
// Configuration register file for the alignment sequencer.
// Depends on fas_pkg for register indexes, reset values and cfg_type.
module fas_csr
   import fas_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_OFFSET_THRESHOLD: cfg_in.offset_threshold = csr_data[14:0];
            CSR_TILT_THRESHOLD:   cfg_in.tilt_threshold   = csr_data[15:0];
            CSR_OFFSET_WINDOW:    cfg_in.offset_window    = csr_data[14:0];
            CSR_AREA_TOLERANCE:   cfg_in.area_tolerance   = csr_data[15:0];
            CSR_AREA_TARGET:      cfg_in.area_target      = $signed(csr_data[16:0]);
            CSR_STRAFE_GAIN:      cfg_in.strafe_gain      = csr_data[6:0];
            CSR_DRIVE_GAIN:       cfg_in.drive_gain       = csr_data[6:0];
            CSR_ROTATE_SPEED:     cfg_in.rotate_speed     = csr_data[6:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers, load defaults on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_threshold <= RST_OFFSET_THRESHOLD;
         cfg_ff.tilt_threshold   <= RST_TILT_THRESHOLD;
         cfg_ff.offset_window    <= RST_OFFSET_WINDOW;
         cfg_ff.area_tolerance   <= RST_AREA_TOLERANCE;
         cfg_ff.area_target      <= RST_AREA_TARGET;
         cfg_ff.strafe_gain      <= RST_STRAFE_GAIN;
         cfg_ff.drive_gain       <= RST_DRIVE_GAIN;
         cfg_ff.rotate_speed     <= RST_ROTATE_SPEED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/fas_step.sv */
// Per-sample sequencer step: phase register, held readings and the command
// decision for one sample word. Depends on fas_pkg.
module fas_step
   import fas_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_word_type item,
   input  cfg_type      cfg,
   output rsp_word_type result
);

   phase_type          phase_ff, phase_in;
   logic signed [15:0] held_offset_ff, held_offset_in;
   logic signed [16:0] held_tilt_ff, held_tilt_in;
   logic [15:0]        held_area_ff, held_area_in;

   logic signed [16:0] tilt_raw;
   logic signed [15:0] off_base, off_cur;
   logic signed [16:0] tilt_base, tilt_cur;
   logic [15:0]        area_cur;
   logic [16:0]        aoff;
   logic [16:0]        atilt_w;
   logic [15:0]        atilt;
   logic               start;
   phase_type          phase_a, phase_b;
   logic [6:0]         gain_sel;
   logic [16:0]        area_room;
   logic [23:0]        product;
   logic [15:0]        scaled;
   logic [14:0]        scaled_speed;
   logic [14:0]        rot_raw;
   logic [14:0]        rot_speed;
   logic signed [17:0] area_lo, area_hi, area_now;

   // Pick up the sample, fold in held readings, form magnitudes
   always_comb begin
      phase_a  = item.restart ? PH_WAIT : phase_ff;
      start    = (phase_a == PH_WAIT) && item.target_seen;
      tilt_raw = $signed({1'b0, item.right_corner_y}) - $signed({1'b0, item.left_corner_y});

      off_base  = start ? 16'sd0 : held_offset_ff;
      tilt_base = start ? 17'sd0 : held_tilt_ff;
      off_cur   = (item.offset_sample != 16'sd0) ? item.offset_sample : off_base;
      tilt_cur  = (tilt_raw != 17'sd0) ? tilt_raw : tilt_base;
      area_cur  = (item.area_sample != 16'd0) ? item.area_sample : held_area_ff;

      aoff    = off_cur[15] ? (17'd0 - {off_cur[15], off_cur}) : {1'b0, off_cur};
      atilt_w = tilt_cur[16] ? (17'd0 - tilt_cur) : tilt_cur;
      atilt   = atilt_w[15:0];

      if (start) begin
         phase_a = PH_STRAFE;
      end
   end

   // Area-scaled speed: one multiplier shared by strafe and drive
   always_comb begin
      gain_sel  = (phase_a == PH_STRAFE) ? cfg.strafe_gain : cfg.drive_gain;
      area_room = AREA_FULL - {1'b0, area_cur};
      product   = 24'(gain_sel) * 24'(area_room);
      scaled    = product[23:8];
      scaled_speed = (scaled > 16'(SPEED_MAX)) ? SPEED_MAX : scaled[14:0];

      rot_raw   = {cfg.rotate_speed, 8'd0};
      rot_speed = (rot_raw > SPEED_MAX) ? SPEED_MAX : rot_raw;

      area_now = $signed({2'b00, area_cur});
      area_lo  = $signed({cfg.area_target[16], cfg.area_target})
               - $signed({2'b00, cfg.area_tolerance});
      area_hi  = $signed({cfg.area_target[16], cfg.area_target})
               + $signed({2'b00, cfg.area_tolerance});
   end

   // Phase decision and command
   always_comb begin
      result.drive_command = CMD_NONE;
      result.drive_speed   = 15'd0;
      held_offset_in = off_cur;
      held_tilt_in   = tilt_cur;
      held_area_in   = area_cur;
      phase_b        = phase_a;

      // Strafe until centred, else fall into rotate on this sample
      if (phase_a == PH_STRAFE) begin
         if (aoff > {2'b00, cfg.offset_threshold}) begin
            result.drive_command = off_cur[15] ? CMD_LEFT : CMD_RIGHT;
            result.drive_speed   = scaled_speed;
         end else begin
            phase_b = PH_ROTATE;
         end
      end

      phase_in = phase_b;
      case (phase_b)
         PH_ROTATE: begin
            if ((atilt > cfg.tilt_threshold) && (aoff < {2'b00, cfg.offset_window})) begin
               result.drive_command = tilt_cur[16] ? CMD_CCW : CMD_CW;
               result.drive_speed   = rot_speed;
            end else begin
               result.drive_command = CMD_STOP;
               result.drive_speed   = 15'd0;
               if ((aoff <= {2'b00, cfg.offset_threshold}) &&
                   (atilt <= cfg.tilt_threshold)) begin
                  if (cfg.area_target[16]) begin
                     held_offset_in = 16'sd0;
                     held_tilt_in   = 17'sd0;
                     phase_in       = PH_FINAL;
                  end else begin
                     held_area_in = 16'd0;
                     phase_in     = PH_DIST;
                  end
               end else begin
                  held_offset_in = 16'sd0;
                  held_tilt_in   = 17'sd0;
                  phase_in       = PH_STRAFE;
               end
            end
         end
         PH_DIST: begin
            if (area_now < area_lo) begin
               result.drive_command = CMD_FWD;
               result.drive_speed   = scaled_speed;
            end else if (area_now > area_hi) begin
               result.drive_command = CMD_BACK;
               result.drive_speed   = scaled_speed;
            end else begin
               result.drive_command = CMD_STOP;
               held_offset_in = 16'sd0;
               held_tilt_in   = 17'sd0;
               phase_in       = PH_FINAL;
            end
         end
         PH_FINAL: begin
            result.drive_command = CMD_STOP;
            if ((aoff < {2'b00, cfg.offset_threshold}) && (atilt < cfg.tilt_threshold)) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_WAIT;
            end
         end
         PH_DONE: begin
            result.drive_command = CMD_STOP;
         end
         default: begin
            // waiting or strafing: command already set above
         end
      endcase

      result.phase    = phase_in;
      result.done_res = (phase_in == PH_DONE);
   end

   // Advance the sequencer state when the word moves to the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_WAIT;
         held_offset_ff <= 16'sd0;
         held_tilt_ff   <= 17'sd0;
         held_area_ff   <= 16'd0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         held_offset_ff <= held_offset_in;
         held_tilt_ff   <= held_tilt_in;
         held_area_ff   <= held_area_in;
      end
   end

endmodule

/* design/fiducial_alignment_sequencer.sv */
// Fiducial alignment sequencer top level: sample register, step logic, result register.
// Path: a sample word is held in the sample register, and its command word in the result register.
// Throughput: one word per cycle while the command channel takes words; a stall there holds both registers.
// Reset: pipeline empties, phase returns to wait, held readings clear, registers take defaults.
// Depends on fas_pkg, fas_req_if, fas_rsp_if, fas_csr and fas_step.
module fiducial_alignment_sequencer
   import fas_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   fas_req_if.sink                req_chan,
   fas_rsp_if.source              rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type      cfg;
   req_word_type req_word;
   req_word_type s1_word_ff;
   logic         s1_valid_ff, s1_valid_in;
   rsp_word_type step_word;
   rsp_word_type rsp_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance;
   logic         req_take;

   fas_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   fas_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (s1_word_ff),
      .cfg     (cfg),
      .result  (step_word)
   );

   // Gather the incoming word
   always_comb begin
      req_word.restart        = req_chan.restart;
      req_word.target_seen    = req_chan.target_seen;
      req_word.offset_sample  = req_chan.offset_sample;
      req_word.area_sample    = req_chan.area_sample;
      req_word.left_corner_y  = req_chan.left_corner_y;
      req_word.right_corner_y = req_chan.right_corner_y;
   end

   // Move a word forward when the result stage is free or being drained
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take     = req_chan.valid && req_chan.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   // Pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= step_word;
      end
   end

   // Drive the command channel
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.drive_command = rsp_word_ff.drive_command;
   assign rsp_chan.drive_speed   = rsp_word_ff.drive_speed;
   assign rsp_chan.phase         = rsp_word_ff.phase;
   assign rsp_chan.done_res      = rsp_word_ff.done_res;

endmodule

/* dv/testbench.sv */
// Self-checking bench for the fiducial alignment sequencer: random-stall handshakes,
// register phases and a per-sample phase/command predictor. Needs fas_pkg,
// fas_req_if, fas_rsp_if and the fiducial_alignment_sequencer top level.
module testbench;
   import fas_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PER_PH = 125;
   localparam int NUM_PHASES    = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_data     = '0;

   // Bench-side copies of what goes onto each channel
   logic         req_valid_q = 1'b0;
   req_word_type req_word_q  = '0;
   logic         rsp_ready_q = 1'b0;
   logic         req_taken   = 1'b0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int queued_count  = 0;
   int checked_count = 0;
   int mismatch_count = 0;
   int idle_cycles   = 0;

   req_word_type pending_samples[$];
   rsp_word_type expected_cmds[$];

   // Predictor state and register copy
   cfg_type            cur_cfg = '{RST_OFFSET_THRESHOLD, RST_TILT_THRESHOLD, RST_OFFSET_WINDOW,
                                   RST_AREA_TOLERANCE, RST_AREA_TARGET, RST_STRAFE_GAIN,
                                   RST_DRIVE_GAIN, RST_ROTATE_SPEED};
   phase_type          seq_phase = PH_WAIT;
   logic signed [15:0] hold_off  = '0;
   logic signed [16:0] hold_tilt = '0;
   logic [15:0]        hold_area = '0;

   fas_req_if req_bus ();
   fas_rsp_if rsp_bus ();

   assign req_bus.valid          = req_valid_q;
   assign req_bus.restart        = req_word_q.restart;
   assign req_bus.target_seen    = req_word_q.target_seen;
   assign req_bus.offset_sample  = req_word_q.offset_sample;
   assign req_bus.area_sample    = req_word_q.area_sample;
   assign req_bus.left_corner_y  = req_word_q.left_corner_y;
   assign req_bus.right_corner_y = req_word_q.right_corner_y;
   assign rsp_bus.ready          = rsp_ready_q;

   fiducial_alignment_sequencer dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Speed that falls as the held area grows, saturated at full scale
   function automatic logic [14:0] area_scaled_speed(input int gain);
      int s;
      s = (gain * (65536 - int'(hold_area))) >> 8;
      return (s > int'(SPEED_MAX)) ? SPEED_MAX : s[14:0];
   endfunction

   // Advance the predicted sequencer by one sample and return its command word
   function automatic rsp_word_type step_sequencer(input req_word_type s);
      rsp_word_type r;
      cmd_type      cmd;
      int           spd, off, tilt, aoff, atilt, othr, tthr, tgt, tol, area_now;
      cmd   = CMD_NONE;
      spd   = 0;
      off   = int'(s.offset_sample);
      tilt  = int'(s.right_corner_y) - int'(s.left_corner_y);
      othr  = int'(cur_cfg.offset_threshold);
      tthr  = int'(cur_cfg.tilt_threshold);
      tgt   = int'(cur_cfg.area_target);
      tol   = int'(cur_cfg.area_tolerance);

      if (s.restart) seq_phase = PH_WAIT;
      // A new target restarts centring from scratch
      if (seq_phase == PH_WAIT && s.target_seen) begin
         hold_off  = '0;
         hold_tilt = '0;
         seq_phase = PH_STRAFE;
      end

      // Hold the last nonzero readings
      if (off != 0) hold_off = off[15:0];
      if (tilt != 0) hold_tilt = tilt[16:0];
      if (s.area_sample != 0) hold_area = s.area_sample;
      aoff  = (hold_off < 0) ? -int'(hold_off) : int'(hold_off);
      atilt = (hold_tilt < 0) ? -int'(hold_tilt) : int'(hold_tilt);

      if (seq_phase == PH_STRAFE) begin
         if (aoff > othr) begin
            cmd = (hold_off < 0) ? CMD_LEFT : CMD_RIGHT;
            spd = int'(area_scaled_speed(int'(cur_cfg.strafe_gain)));
         end else begin
            seq_phase = PH_ROTATE;
         end
      end

      if (seq_phase == PH_ROTATE) begin
         if (atilt > tthr && aoff < int'(cur_cfg.offset_window)) begin
            cmd = (hold_tilt < 0) ? CMD_CCW : CMD_CW;
            spd = int'(cur_cfg.rotate_speed) * 256;
            if (spd > int'(SPEED_MAX)) spd = int'(SPEED_MAX);
         end else begin
            cmd = CMD_STOP;
            spd = 0;
            if (aoff <= othr && atilt <= tthr) begin
               if (tgt < 0) begin
                  hold_off  = '0;
                  hold_tilt = '0;
                  seq_phase = PH_FINAL;
               end else begin
                  hold_area = '0;
                  seq_phase = PH_DIST;
               end
            end else begin
               hold_off  = '0;
               hold_tilt = '0;
               seq_phase = PH_STRAFE;
            end
         end
      end else if (seq_phase == PH_DIST) begin
         area_now = int'(hold_area);
         if (area_now < tgt - tol) begin
            cmd = CMD_FWD;
            spd = int'(area_scaled_speed(int'(cur_cfg.drive_gain)));
         end else if (area_now > tgt + tol) begin
            cmd = CMD_BACK;
            spd = int'(area_scaled_speed(int'(cur_cfg.drive_gain)));
         end else begin
            cmd       = CMD_STOP;
            hold_off  = '0;
            hold_tilt = '0;
            seq_phase = PH_FINAL;
         end
      end else if (seq_phase == PH_FINAL) begin
         cmd       = CMD_STOP;
         seq_phase = (aoff < othr && atilt < tthr) ? PH_DONE : PH_WAIT;
      end else if (seq_phase == PH_DONE) begin
         cmd = CMD_STOP;
      end

      r.drive_command = cmd;
      r.drive_speed   = spd[14:0];
      r.phase         = seq_phase;
      r.done_res      = (seq_phase == PH_DONE);
      return r;
   endfunction

   function automatic int sym_rand(input int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   function automatic logic [15:0] clamp_u16(input int v);
      return (v < 0) ? 16'd0 : ((v > 65535) ? 16'hFFFF : v[15:0]);
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic push_sample(input logic rs, input logic seen, input int off, input int area,
                              input int left, input int right);
      req_word_type s;
      s.restart        = rs;
      s.target_seen    = seen;
      s.offset_sample  = off[15:0];
      s.area_sample    = area[15:0];
      s.left_corner_y  = left[15:0];
      s.right_corner_y = right[15:0];
      pending_samples.push_back(s);
      queued_count++;
   endtask

   // Write one register and mirror it into the predictor
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_OFFSET_THRESHOLD: cur_cfg.offset_threshold = value[14:0];
         CSR_TILT_THRESHOLD:   cur_cfg.tilt_threshold   = value[15:0];
         CSR_OFFSET_WINDOW:    cur_cfg.offset_window    = value[14:0];
         CSR_AREA_TOLERANCE:   cur_cfg.area_tolerance   = value[15:0];
         CSR_AREA_TARGET:      cur_cfg.area_target      = value;
         CSR_STRAFE_GAIN:      cur_cfg.strafe_gain      = value[6:0];
         CSR_DRIVE_GAIN:       cur_cfg.drive_gain       = value[6:0];
         CSR_ROTATE_SPEED:     cur_cfg.rotate_speed     = value[6:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input cfg_type c);
      write_reg(CSR_OFFSET_THRESHOLD, 17'(c.offset_threshold));
      write_reg(CSR_TILT_THRESHOLD,   17'(c.tilt_threshold));
      write_reg(CSR_OFFSET_WINDOW,    17'(c.offset_window));
      write_reg(CSR_AREA_TOLERANCE,   17'(c.area_tolerance));
      write_reg(CSR_AREA_TARGET,      c.area_target);
      write_reg(CSR_STRAFE_GAIN,      17'(c.strafe_gain));
      write_reg(CSR_DRIVE_GAIN,       17'(c.drive_gain));
      write_reg(CSR_ROTATE_SPEED,     17'(c.rotate_speed));
   endtask

   // Mostly episodes of readings near the deadbands and, for a target that is not negative,
   // areas near the target, with some zero readings and raw noise mixed in
   task automatic queue_random_samples(input int count);
      int   ep_left, roll, othr, tthr, tol, tgt, off, area, left, right;
      logic rs, seen;
      ep_left = 0;
      othr    = int'(cur_cfg.offset_threshold);
      tthr    = int'(cur_cfg.tilt_threshold);
      tol     = int'(cur_cfg.area_tolerance);
      tgt     = int'(cur_cfg.area_target);
      for (int i = 0; i < count; i++) begin
         if (ep_left == 0) begin
            ep_left = $urandom_range(6, 40);
            rs      = ($urandom_range(99) < 80);
            seen    = 1'b1;
         end else begin
            rs   = ($urandom_range(99) < 2);
            seen = ($urandom_range(99) < 85);
         end
         ep_left--;
         if ($urandom_range(99) < 10) begin
            push_sample(rs, seen, $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
         end else begin
            roll = $urandom_range(99);
            if (roll < 15) off = 0;
            else if (roll < 60) off = sym_rand((2 * othr + 2 > 32767) ? 32767 : 2 * othr + 2);
            else if (roll < 85) off = sym_rand((8 * othr + 64 > 32767) ? 32767 : 8 * othr + 64);
            else off = $urandom_range(0, 65535);

            left = $urandom_range(0, 65535);
            roll = $urandom_range(99);
            if (roll < 15) right = left;
            else if (roll < 60) right = int'(clamp_u16(left + sym_rand(2 * tthr + 2)));
            else if (roll < 85) right = int'(clamp_u16(left + sym_rand(8 * tthr + 16)));
            else right = $urandom_range(0, 65535);

            roll = $urandom_range(99);
            if (roll < 15) area = 0;
            else if (roll < 65 && tgt >= 0) area = int'(clamp_u16(tgt + sym_rand(2 * tol + 2)));
            else area = $urandom_range(0, 65535);

            push_sample(rs, seen, off, area, left, right);
         end
      end
   endtask

   // Driver: present the next sample word, hold it until taken, toggle ready
   always @(negedge clock) begin : driver
      if (reset) begin
         req_valid_q <= 1'b0;
         rsp_ready_q <= 1'b0;
      end else begin
         if (!req_valid_q || req_taken) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_word_q  <= pending_samples.pop_front();
               req_valid_q <= 1'b1;
            end else begin
               req_valid_q <= 1'b0;
            end
         end
         rsp_ready_q <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: check each command word, then predict for each accepted sample
   always @(posedge clock) begin : monitor
      rsp_word_type want;
      logic         req_fire, rsp_fire;
      req_fire = req_bus.valid && req_bus.ready;
      rsp_fire = rsp_bus.valid && rsp_bus.ready;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_fire) begin
            if (expected_cmds.size() == 0) begin
               $display("%0t: unexpected command word, expected none, actual cmd %0d phase %0d",
                        $time, rsp_bus.drive_command, rsp_bus.phase);
               mismatch_count++;
            end else begin
               want = expected_cmds.pop_front();
               check_field("drive_command", int'(want.drive_command),
                           int'(rsp_bus.drive_command));
               check_field("drive_speed", int'(want.drive_speed), int'(rsp_bus.drive_speed));
               check_field("phase", int'(want.phase), int'(rsp_bus.phase));
               check_field("done_res", int'(want.done_res), int'(rsp_bus.done_res));
               checked_count++;
            end
         end
         if (req_fire) expected_cmds.push_back(step_sequencer(req_word_q));
         req_taken <= req_fire;

         // Watchdog on cycles with no word moving
         if (req_fire || rsp_fire) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("end of test: mismatches");
               $finish;
            end
         end
      end
   end

   initial begin : sequencer_test
      cfg_type c;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph < 2) begin
            send_idle_pct = 33;
            recv_idle_pct = 87;
         end else if (ph < 4) begin
            send_idle_pct = 87;
            recv_idle_pct = 33;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         c = cur_cfg;
         case (ph)
            1: begin
               c.offset_threshold = 15'($urandom_range(256, 2000));
               c.tilt_threshold   = 16'($urandom_range(8, 200));
               c.offset_window    = 15'($urandom_range(2000, 8000));
               c.area_tolerance   = 16'($urandom_range(500, 4000));
               c.area_target      = 17'($urandom_range(5000, 60000));
               c.strafe_gain      = 7'($urandom_range(0, 100));
               c.drive_gain       = 7'($urandom_range(0, 100));
               c.rotate_speed     = 7'($urandom_range(0, 100));
            end
            2: c = '{15'h7FFF, 16'hFFFF, 15'h7FFF, 16'hFFFF, 17'sd65535, 7'd100, 7'd100, 7'd100};
            3: c = '0;
            4: begin
               c.offset_threshold = 15'($urandom_range(0, 3000));
               c.tilt_threshold   = 16'($urandom_range(0, 400));
               c.offset_window    = 15'($urandom_range(0, 32767));
               c.area_tolerance   = 16'($urandom_range(0, 8000));
               c.area_target      = 17'($urandom_range(0, 65535));
               c.strafe_gain      = 7'($urandom_range(0, 100));
               c.drive_gain       = 7'($urandom_range(0, 100));
               c.rotate_speed     = 7'($urandom_range(0, 100));
            end
            5: begin
               c.offset_threshold = 15'($urandom_range(256, 2000));
               c.tilt_threshold   = 16'($urandom_range(8, 200));
               c.offset_window    = 15'($urandom_range(0, 32767));
               c.area_tolerance   = 16'($urandom_range(0, 65535));
               c.area_target      = -17'sd1;
               c.strafe_gain      = 7'($urandom_range(0, 100));
               c.drive_gain       = 7'($urandom_range(0, 100));
               c.rotate_speed     = 7'($urandom_range(0, 100));
            end
            default: ;
         endcase
         if (ph != 0) program_regs(c);

         // Directed walk under the reset register values
         if (ph == 0) begin
            push_sample(1'b0, 1'b0, 0, 0, 0, 0);               // wait, no target
            push_sample(1'b0, 1'b0, -32768, 65535, 0, 65535);  // readings held while waiting
            push_sample(1'b0, 1'b1, 32767, 0, 65535, 0);       // leave wait, strafe at full area
            push_sample(1'b0, 1'b1, -2000, 1, 100, 100);       // strafe left, near-zero area
            push_sample(1'b0, 1'b1, 100, 0, 100, 300);         // centred, rotate clockwise
            push_sample(1'b0, 1'b1, 0, 0, 300, 100);           // rotate counterclockwise
            push_sample(1'b0, 1'b1, 3000, 0, 0, 0);            // offset leaves window, strafe
            push_sample(1'b0, 1'b1, 768, 0, 0, 0);             // deadband edge, level, final
            push_sample(1'b0, 1'b1, 0, 0, 0, 0);               // final check passes
            push_sample(1'b0, 1'b0, 5000, 9, 1, 2);            // stay done
            push_sample(1'b1, 1'b0, 0, 0, 0, 0);               // restart without target
            push_sample(1'b1, 1'b1, 767, 0, 0, 47);            // restart straight into final
            push_sample(1'b0, 1'b1, 768, 0, 0, 0);             // final check fails at the edge
            push_sample(1'b0, 1'b1, -800, 0, 200, 152);        // strafe left with tilt at edge
            push_sample(1'b0, 1'b1, -768, 0, 0, 0);            // level at tilt edge
            push_sample(1'b0, 1'b1, 0, 0, 0, 0);               // done
            push_sample(1'b1, 1'b1, 0, 0, 0, 0);               // restart with no offset or tilt held
            push_sample(1'b0, 1'b1, 0, 0, 0, 0);
         end
         queue_random_samples(RANDOM_PER_PH);

         // Drain before touching the registers again
         while (checked_count != queued_count) @(negedge clock);
         repeat (4) @(negedge clock);
      end

      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
